[rtl/bcd_digit_display_driver_core_defines.svh]
// Assertion macros used by the BCD display driver RTL.
`ifndef BCD_DIGIT_DISPLAY_DRIVER_CORE_DEFINES_SVH
`define BCD_DIGIT_DISPLAY_DRIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BCDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BCDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bcdd_pkg.sv]
// Types and constants for the BCD display driver.
`timescale 1ns / 1ps

package bcdd_pkg;

    localparam int BCD_W       = 4;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 8;
    localparam int SEL_W       = 4;
    localparam int CNT_W       = 4;

    localparam logic [BCD_W-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [BCD_W-1:0] DIGIT_ADJ_ADD = 4'd3;
    localparam logic [BCD_W-1:0] DIGIT_MAX     = 4'd9;
    localparam logic [CNT_W-1:0] CFG_COUNT_RST = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } t_state;

endpackage

[rtl/bcdd_dabble_step.sv]
// One shift-and-add-3 step of the binary to BCD conversion.
`timescale 1ns / 1ps

module bcdd_dabble_step #(
    parameter int NUM_DIGITS = 10
) (
    input  logic [bcdd_pkg::BCD_W*NUM_DIGITS-1:0] i_bcd,
    input  logic                                  i_bit,
    output logic [bcdd_pkg::BCD_W*NUM_DIGITS-1:0] o_bcd
);

    localparam int W = bcdd_pkg::BCD_W * NUM_DIGITS;

    logic [W-1:0] adj;

    // Each digit of five or more gets three added so that the shift carries into the next.
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_digit
        logic [bcdd_pkg::BCD_W-1:0] d;
        assign d = i_bcd[g*bcdd_pkg::BCD_W +: bcdd_pkg::BCD_W];
        assign adj[g*bcdd_pkg::BCD_W +: bcdd_pkg::BCD_W] =
            (d >= bcdd_pkg::DIGIT_ADJ_MIN) ? d + bcdd_pkg::DIGIT_ADJ_ADD : d;
    end

    // The top bit falls off: only the low NUM_DIGITS digits are kept.
    assign o_bcd = {adj[W-2:0], i_bit};

endmodule

[rtl/bcd_digit_display_driver_core.sv]
// Top level of the binary to BCD driver for a multiplexed decimal display.
`timescale 1ns / 1ps

// Each request on the slave stream carries one unsigned binary value, of which
// the low VALUE_WIDTH bits are used. The block converts it to decimal with the
// shift-and-add-3 method and then sends one request per shown digit on the
// master stream, most significant shown digit first, with the BCD code, the
// index of the select line to strobe (0 is the leftmost digit shown) and
// tlast on the final digit. The number of digits N comes from the digit count
// register: 0 acts as 1 and values above MAX_DIGITS act as MAX_DIGITS. Higher
// digits are dropped, so the digits shown are the value modulo 10 to the N.
// When the sink never stalls, a value is accepted, then its input bits pass
// one per cycle through the single shift-and-add-3 unit, and then its digits
// leave one per cycle through the output register.
// The slave side is ready only between values, but it becomes ready again
// while the last digit still waits in the output register. The digit count
// register is written through i_cfg_wr_en and i_cfg_wr_data and must only
// change while no value is in flight.
module bcd_digit_display_driver_core #(
    parameter int MAX_DIGITS  = 10,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Digit count register write.
    input  logic                            i_cfg_wr_en,
    input  logic [bcdd_pkg::CNT_W-1:0]      i_cfg_wr_data,
    // Slave stream. tdata: [31:0] value.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bcdd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Master stream. tdata: [3:0] bcd_code, [7:4] digit_select.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bcdd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

`include "bcd_digit_display_driver_core_defines.svh"

    localparam int BCD_VEC_W = bcdd_pkg::BCD_W * MAX_DIGITS;
    localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [bcdd_pkg::CNT_W-1:0] MAX_DIG_CNT = bcdd_pkg::CNT_W'(MAX_DIGITS);
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_INIT = BIT_CNT_W'(VALUE_WIDTH);

    bcdd_pkg::t_state r_state, n_state;

    logic [bcdd_pkg::CNT_W-1:0] r_digit_count;
    logic [bcdd_pkg::CNT_W-1:0] r_ndig, n_ndig;
    logic [bcdd_pkg::SEL_W-1:0] r_idx, n_idx;
    logic [BIT_CNT_W-1:0]       r_bitcnt, n_bitcnt;
    logic [VALUE_WIDTH-1:0]     r_bin, n_bin;
    logic [BCD_VEC_W-1:0]       r_bcd, n_bcd;
    logic [BCD_VEC_W-1:0]       step_bcd;

    logic                        r_out_valid, n_out_valid;
    logic [bcdd_pkg::BCD_W-1:0]  r_out_code, n_out_code;
    logic [bcdd_pkg::SEL_W-1:0]  r_out_sel, n_out_sel;
    logic                        r_out_last, n_out_last;

    logic [bcdd_pkg::CNT_W-1:0] eff_count;
    logic [bcdd_pkg::CNT_W-1:0] digit_pos;
    logic [bcdd_pkg::BCD_W-1:0] digit_val;
    logic                       in_take;
    logic                       out_free;
    logic                       is_final;

    // The register keeps the raw write; the clamp applies when a value is taken.
    always_comb begin
        if (r_digit_count == '0) begin
            eff_count = bcdd_pkg::CNT_W'(1);
        end else if (r_digit_count > MAX_DIG_CNT) begin
            eff_count = MAX_DIG_CNT;
        end else begin
            eff_count = r_digit_count;
        end
    end

    // The shared conversion unit: one add-3 pass and one shift per cycle.
    bcdd_dabble_step #(
        .NUM_DIGITS (MAX_DIGITS)
    ) u_step (
        .i_bcd (r_bcd),
        .i_bit (r_bin[VALUE_WIDTH-1]),
        .o_bcd (step_bcd)
    );

    assign s_axis_tready = (r_state == bcdd_pkg::ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Digits leave most significant first, so the select index counts up while
    // the position in the BCD vector counts down from N - 1.
    assign digit_pos = r_ndig - bcdd_pkg::CNT_W'(1) - r_idx;
    assign digit_val = r_bcd[digit_pos[DIG_IDX_W-1:0]*bcdd_pkg::BCD_W +: bcdd_pkg::BCD_W];
    assign is_final  = (r_idx == r_ndig - bcdd_pkg::CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_ndig      = r_ndig;
        n_idx       = r_idx;
        n_bitcnt    = r_bitcnt;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_code  = r_out_code;
        n_out_sel   = r_out_sel;
        n_out_last  = r_out_last;

        unique case (r_state)
            bcdd_pkg::ST_IDLE: begin
                if (in_take) begin
                    n_bin    = s_axis_tdata[VALUE_WIDTH-1:0];
                    n_bcd    = '0;
                    n_bitcnt = BIT_CNT_INIT;
                    n_ndig   = eff_count;
                    n_state  = bcdd_pkg::ST_CONVERT;
                end
            end
            bcdd_pkg::ST_CONVERT: begin
                n_bcd    = step_bcd;
                n_bin    = r_bin << 1;
                n_bitcnt = r_bitcnt - BIT_CNT_W'(1);
                if (r_bitcnt == BIT_CNT_W'(1)) begin
                    n_idx   = '0;
                    n_state = bcdd_pkg::ST_EMIT;
                end
            end
            bcdd_pkg::ST_EMIT: begin
                // A digit moves into the output register whenever it is empty or
                // being emptied in this cycle.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = digit_val;
                    n_out_sel   = r_idx;
                    n_out_last  = is_final;
                    n_idx       = r_idx + bcdd_pkg::SEL_W'(1);
                    if (is_final) begin
                        n_state = bcdd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = bcdd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bcdd_pkg::ST_IDLE;
            r_digit_count <= bcdd_pkg::CFG_COUNT_RST;
            r_out_valid   <= 1'b0;
            r_ndig        <= '0;
            r_idx         <= '0;
            r_bitcnt      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ndig      <= n_ndig;
            r_idx       <= n_idx;
            r_bitcnt    <= n_bitcnt;
            if (i_cfg_wr_en) begin
                r_digit_count <= i_cfg_wr_data;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_out_code <= n_out_code;
        r_out_sel  <= n_out_sel;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_sel, r_out_code};
    assign m_axis_tlast  = r_out_last;

    // Every digit that leaves must be a valid decimal digit.
    `BCDD_ASSERT_NOW(a_digit_decimal, m_axis_tvalid, m_axis_tdata[3:0] <= bcdd_pkg::DIGIT_MAX, "digit out of range")
    // After a non-final digit is taken, the next digit follows without a gap.
    `BCDD_ASSERT_NEXT(a_digits_back_to_back, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside a digit run")
    // A taken value always starts a conversion with a sane digit count.
    `BCDD_ASSERT_NEXT(a_accept_starts_convert, in_take, (r_state == bcdd_pkg::ST_CONVERT) && (r_ndig != '0) && (r_ndig <= MAX_DIG_CNT), "bad start of conversion")

endmodule
